/* hw/rtl/data_channel_hop_select_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the data channel hop selector
// Immediate-consequence and next-cycle-consequence property forms.
// ----------------------------------------------------------------------------
`ifndef DATA_CHANNEL_HOP_SELECT_ASSERT_SVH
`define DATA_CHANNEL_HOP_SELECT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DCHS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define DCHS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dchs_pkg.sv */
// ----------------------------------------------------------------------------
// dchs_pkg
// Shared types and fixed constants of the data channel hop selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dchs_pkg;

  localparam int CHAN_W      = 6;
  localparam int HOP_W       = 5;
  localparam int CFG_DATA_W  = 37;
  localparam int CFG_INDEX_W = 4;
  localparam int HOP_RESET   = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MAP   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_HOP_INCREMENT = CFG_INDEX_W'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic wr_map;
    logic wr_hop;
    logic load_item;
    logic take_unmapped;
    logic start_modc;
    logic start_count;
    logic start_select;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_end;
    logic scan_end;
    logic unmapped_enabled;
    logic map_empty;
  } sts_t;

endpackage

/* hw/rtl/dchs_ctrl.sv */
// ----------------------------------------------------------------------------
// dchs_ctrl
// Sequencer: config writes, modulo steps, remap scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dchs_ctrl import dchs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  output logic                   cfg_ready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   out_free,
  input  sts_t                   sts,
  output cmd_t                   cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_RECOUNT = 6'b000010,
    S_CHECK   = 6'b000100,
    S_MODC    = 6'b001000,
    S_SCAN    = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cfg_ready  = 1'b0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        priority if (cfg_valid) begin
          if (cfg_index == REG_CHANNEL_MAP) begin
            cmd.wr_map      = 1'b1;
            cmd.start_count = 1'b1;
            state_next      = S_RECOUNT;
          end else if (cfg_index == REG_HOP_INCREMENT) begin
            cmd.wr_hop = 1'b1;
          end
        end else if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RECOUNT: begin
        if (sts.scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.take_unmapped = 1'b1;
        if (sts.map_empty || sts.unmapped_enabled) begin
          state_next = S_FINISH;
        end else begin
          cmd.start_modc = 1'b1;
          state_next     = S_MODC;
        end
      end
      S_MODC: begin
        if (sts.div_end) begin
          cmd.start_select = 1'b1;
          state_next       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/dchs_dp.sv */
// ----------------------------------------------------------------------------
// dchs_dp
// Config registers, restoring remainder unit and channel map scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "data_channel_hop_select_assert.svh"

module dchs_dp import dchs_pkg::*; #(
  parameter int NUM_DATA_CHANNELS = 37
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  restart,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [CHAN_W-1:0]     data_channel,
  output logic [CHAN_W-1:0]     unmapped_channel,
  output logic                  was_remapped,
  output logic                  map_empty
);

  localparam int CHW  = $clog2(NUM_DATA_CHANNELS);
  localparam int CNTW = $clog2(NUM_DATA_CHANNELS + 1);
  localparam int DW   = $clog2(NUM_DATA_CHANNELS + (1 << HOP_W) - 1);
  localparam int STW  = $clog2(DW + 1);
  localparam int RESET_COUNT =
    (NUM_DATA_CHANNELS < CFG_DATA_W) ? NUM_DATA_CHANNELS : CFG_DATA_W;

  logic [NUM_DATA_CHANNELS-1:0] map_load;
  logic [NUM_DATA_CHANNELS-1:0] map_init;

  logic [NUM_DATA_CHANNELS-1:0] channel_map;
  logic [HOP_W-1:0]             hop_inc;
  logic [CNTW-1:0]              used_count;
  logic [CHW-1:0]               last_unmapped;

  logic [CNTW-1:0] div_rem;
  logic [DW-1:0]   div_dvd;
  logic [CNTW-1:0] div_den;
  logic [STW-1:0]  div_cnt;
  logic [CNTW:0]   div_try;
  logic [CNTW:0]   div_sub;
  logic            div_ge;
  logic [CNTW-1:0] div_rem_next;

  logic            scan_on;
  logic            scan_sel;
  logic [CNTW-1:0] scan_ch;
  logic [CNTW-1:0] scan_seen;
  logic [CHW-1:0]  scan_idx;
  logic            scan_bit;
  logic            scan_end;

  logic [CHW-1:0]  base;
  logic [DW-1:0]   sum;
  logic [CHW-1:0]  rem_ch;

  logic [CHW-1:0]  res_chosen;
  logic [CHW-1:0]  res_unmapped;
  logic            res_remapped;
  logic            res_empty;

  // Fold the hop sum back into the channel range. The sum stays below
  // NUM_DATA_CHANNELS + 31, so only the multiples up to that bound apply.
  function automatic logic [CHW-1:0] wrap_channel(input logic [DW-1:0] value);
    logic [DW-1:0] r;
    r = value;
    for (int k = DW - 1; k >= 0; k--) begin
      if ((NUM_DATA_CHANNELS << k) <= NUM_DATA_CHANNELS + (1 << HOP_W) - 2) begin
        if (r >= DW'(NUM_DATA_CHANNELS << k)) begin
          r = r - DW'(NUM_DATA_CHANNELS << k);
        end
      end
    end
    return r[CHW-1:0];
  endfunction

  // Map bits above the register width stay disabled.
  for (genvar gi = 0; gi < NUM_DATA_CHANNELS; gi++) begin : g_map
    if (gi < CFG_DATA_W) begin : g_in
      assign map_load[gi] = cfg_data[gi];
      assign map_init[gi] = 1'b1;
    end else begin : g_out
      assign map_load[gi] = 1'b0;
      assign map_init[gi] = 1'b0;
    end
  end

  always_comb begin
    base   = restart ? '0 : last_unmapped;
    sum    = DW'(base) + DW'(hop_inc);
    rem_ch = div_rem[CHW-1:0];

    // One restoring remainder step per cycle
    div_try      = {div_rem, div_dvd[DW-1]};
    div_sub      = div_try - {1'b0, div_den};
    div_ge       = div_try >= {1'b0, div_den};
    div_rem_next = div_ge ? div_sub[CNTW-1:0] : div_try[CNTW-1:0];

    scan_idx = scan_ch[CHW-1:0];
    scan_bit = channel_map[scan_idx];
    scan_end = scan_on && (scan_sel ? (scan_bit && (scan_seen == div_rem))
                                    : (scan_ch == CNTW'(NUM_DATA_CHANNELS - 1)));

    sts.div_end          = (div_cnt == STW'(1));
    sts.scan_end         = scan_end;
    sts.unmapped_enabled = channel_map[rem_ch];
    sts.map_empty        = (used_count == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_map   <= map_init;
      hop_inc       <= HOP_W'(HOP_RESET);
      used_count    <= CNTW'(RESET_COUNT);
      last_unmapped <= '0;
      div_cnt       <= '0;
      scan_on       <= 1'b0;
    end else begin
      if (cmd.wr_map) begin
        channel_map <= map_load;
      end
      if (cmd.wr_hop) begin
        hop_inc <= cfg_data[HOP_W-1:0];
      end
      if (cmd.start_modc) begin
        div_cnt <= STW'(DW);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - STW'(1);
      end
      if (cmd.take_unmapped) begin
        last_unmapped <= rem_ch;
      end
      if (cmd.start_count || cmd.start_select) begin
        scan_on <= 1'b1;
      end else if (scan_end) begin
        scan_on <= 1'b0;
      end
      if (scan_end && !scan_sel) begin
        used_count <= scan_seen + CNTW'(scan_bit);
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_item) begin
      div_rem <= CNTW'(wrap_channel(sum));
    end else if (cmd.start_modc) begin
      div_dvd <= DW'(rem_ch);
      div_den <= used_count;
      div_rem <= '0;
    end else if (div_cnt != '0) begin
      div_dvd <= div_dvd << 1;
      div_rem <= div_rem_next;
    end else begin
      // hold the remainder for the check and the scan
    end

    priority if (cmd.start_count || cmd.start_select) begin
      scan_sel  <= cmd.start_select;
      scan_ch   <= '0;
      scan_seen <= '0;
    end else if (scan_on) begin
      scan_ch <= scan_ch + CNTW'(1);
      if (scan_bit) begin
        scan_seen <= scan_seen + CNTW'(1);
      end
    end else begin
      // hold while the scanner is idle
    end

    if (cmd.take_unmapped) begin
      res_chosen   <= rem_ch;
      res_unmapped <= rem_ch;
      res_remapped <= 1'b0;
      res_empty    <= (used_count == '0);
    end else if (scan_end && scan_sel) begin
      res_chosen   <= scan_idx;
      res_remapped <= 1'b1;
    end
  end

  assign data_channel     = CHAN_W'(res_chosen);
  assign unmapped_channel = CHAN_W'(res_unmapped);
  assign was_remapped     = res_remapped;
  assign map_empty        = res_empty;

  `DCHS_ASSERT_IMP(a_scan_in_range, clk, rst, scan_on,
                   scan_ch < CNTW'(NUM_DATA_CHANNELS), "scan ran past last channel")
  `DCHS_ASSERT_IMP(a_div_scan_excl, clk, rst, div_cnt != '0, !scan_on,
                   "remainder unit and scanner active together")
  `DCHS_ASSERT_NXT(a_remap_enabled, clk, rst, scan_end && scan_sel,
                   channel_map[res_chosen], "remapped channel is not enabled")

endmodule

/* hw/rtl/data_channel_hop_select.sv */
// ----------------------------------------------------------------------------
// data_channel_hop_select
// Flow: a request whose unmapped channel is enabled, or whose map is empty,
//   goes from the check state straight to the finish state; a remapped
//   request first takes DW remainder steps (DW = clog2(NUM_DATA_CHANNELS+31),
//   7 for 37 channels), then scans the map up to the chosen enabled channel.
// Throughput: one request at a time; a config write waiting in idle takes
//   priority over the next request. A channel_map write holds both ports
//   off while the enabled count is rebuilt.
// Reset: synchronous; channels within the register width enabled, hop increment 5, last channel 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "data_channel_hop_select_assert.svh"

module data_channel_hop_select import dchs_pkg::*; #(
  parameter int NUM_DATA_CHANNELS = 37
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   restart,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAN_W-1:0]      data_channel,
  output logic [CHAN_W-1:0]      unmapped_channel,
  output logic                   was_remapped,
  output logic                   map_empty
);

  cmd_t              cmd;
  sts_t              sts;
  logic              out_free;
  logic [CHAN_W-1:0] dp_data_channel;
  logic [CHAN_W-1:0] dp_unmapped_channel;
  logic              dp_was_remapped;
  logic              dp_map_empty;

  // The output register is free when empty or drained this cycle; the
  // controller parks in its finish state until then.
  assign out_free = !out_valid || !out_stall;

  dchs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd)
  );

  dchs_dp #(
    .NUM_DATA_CHANNELS (NUM_DATA_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_data         (cfg_data),
    .restart          (restart),
    .cmd              (cmd),
    .sts              (sts),
    .data_channel     (dp_data_channel),
    .unmapped_channel (dp_unmapped_channel),
    .was_remapped     (dp_was_remapped),
    .map_empty        (dp_map_empty)
  );

  // Result valid: set on hand-off, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: load on hand-off, hold otherwise
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      data_channel     <= dp_data_channel;
      unmapped_channel <= dp_unmapped_channel;
      was_remapped     <= dp_was_remapped;
      map_empty        <= dp_map_empty;
    end
  end

  `DCHS_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, !out_valid || !out_stall,
                   "result overwrote a waiting result")
  `DCHS_ASSERT_NXT(a_emit_valid, clk, rst, cmd.emit, out_valid,
                   "handed-off result not presented")
  `DCHS_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall,
                   "second request accepted while busy")

endmodule
